// ===== rtl/alloc_site_hash_counter_unit_macros.svh =====
// Assertion macros shared by the allocation-site hash counter RTL.
`ifndef ALLOC_SITE_HASH_COUNTER_UNIT_MACROS_SVH
`define ALLOC_SITE_HASH_COUNTER_UNIT_MACROS_SVH

// Checked on every rising edge while the block is out of reset.
`define ASHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASHC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/ashc_pkg.sv =====
// Package with shared types, codes and hash step constants of the hash counter.
`timescale 1ns / 1ps

package ashc_pkg;

    localparam int TABLE_SLOTS_DEFAULT = 256;

    localparam int KEY_W      = 64;
    localparam int OBJ_W      = 32;
    localparam int SLOT_IDX_W = 8;
    localparam int ID_W       = 9;
    localparam int CELL_W     = 32;
    localparam int WORD_W     = 40;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int HASH_W     = 32;

    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAIN    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // Shift amounts of the integer mix. The multiply by 21 is k + 4k + 16k.
    localparam int MIX_SHL_A      = 18;
    localparam int MIX_SHR_A      = 31;
    localparam int MIX_MUL_SHL_LO = 2;
    localparam int MIX_MUL_SHL_HI = 4;
    localparam int MIX_SHR_B      = 11;
    localparam int MIX_SHL_B      = 6;
    localparam int MIX_SHR_C      = 22;

    localparam logic [2:0] MIX_LAST = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   id;
        logic [CELL_W-1:0] cells;
        logic [WORD_W-1:0] words;
    } slot_row_t;

    typedef struct packed {
        logic       inv_a;
        logic       shl;
        logic [5:0] shamt;
        logic       add;
        logic       mul21;
    } mix_op_t;

    function automatic mix_op_t mix_op(input logic [2:0] step);
        mix_op_t op;
        case (step)
            3'd0: op = '{1'b1, 1'b1, 6'(MIX_SHL_A), 1'b1, 1'b0};
            3'd1: op = '{1'b0, 1'b0, 6'(MIX_SHR_A), 1'b0, 1'b0};
            3'd2: op = '{1'b0, 1'b1, 6'(MIX_MUL_SHL_LO), 1'b1, 1'b1};
            3'd3: op = '{1'b0, 1'b0, 6'(MIX_SHR_B), 1'b0, 1'b0};
            3'd4: op = '{1'b0, 1'b1, 6'(MIX_SHL_B), 1'b1, 1'b0};
            default: op = '{1'b0, 1'b0, 6'(MIX_SHR_C), 1'b0, 1'b0};
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/alloc_site_hash_counter_unit.sv =====
// Top level of the allocation-site hash counter: sequencer, slot table and result register.
//
//  Channel  Dir  Handshake           Payload
//  s_       in   s_valid / s_ready   s_mode, s_key, s_object_words, s_slot_index
//  m_       out  m_valid / m_ready   m_status, m_site_id, m_cell_count, m_word_count
//
// Register and count items run through the shared hash mix unit (6 steps), a remainder
// step when TABLE_SLOTS is not a power of two, and a linear probe from the hashed slot
// through the one-slot-per-cycle table read port, which ends at the key, at an empty slot
// or after a full lap. Drain items read one slot; rejected items skip to the result.
// After reset the table is swept to empty before the first item.
// A stalled result sits in the output register while the block already takes the next item.
`timescale 1ns / 1ps
`include "alloc_site_hash_counter_unit_macros.svh"

module alloc_site_hash_counter_unit #(
    parameter int TABLE_SLOTS = ashc_pkg::TABLE_SLOTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ashc_pkg::MODE_W-1:0]      s_mode,
    input  logic [ashc_pkg::KEY_W-1:0]       s_key,
    input  logic [ashc_pkg::OBJ_W-1:0]       s_object_words,
    input  logic [ashc_pkg::SLOT_IDX_W-1:0]  s_slot_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ashc_pkg::STATUS_W-1:0]    m_status,
    output logic [ashc_pkg::ID_W-1:0]        m_site_id,
    output logic [ashc_pkg::CELL_W-1:0]      m_cell_count,
    output logic [ashc_pkg::WORD_W-1:0]      m_word_count
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int ROW_W   = $bits(ashc_pkg::slot_row_t);
    localparam int WSUM_W  = ashc_pkg::WORD_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE, ST_UPDATE, ST_DRAIN, ST_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [ashc_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [ashc_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [ashc_pkg::OBJ_W-1:0]        obj_reg, obj_next;
    logic [SLOT_W-1:0]                 probe_idx_reg, probe_idx_next;
    logic [SLOT_W-1:0]                 probe_cnt_reg, probe_cnt_next;
    logic [SLOT_W-1:0]                 clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]                  entries_reg, entries_next;
    logic                              hit_reg, hit_next;
    ashc_pkg::slot_row_t               row_reg, row_next;
    logic [ashc_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [ashc_pkg::ID_W-1:0]         res_id_reg, res_id_next;
    logic [ashc_pkg::CELL_W-1:0]       res_cells_reg, res_cells_next;
    logic [ashc_pkg::WORD_W-1:0]       res_words_reg, res_words_next;
    logic                              m_valid_reg, m_valid_next;
    logic [ashc_pkg::STATUS_W-1:0]     m_status_reg, m_status_next;
    logic [ashc_pkg::ID_W-1:0]         m_site_id_reg, m_site_id_next;
    logic [ashc_pkg::CELL_W-1:0]       m_cell_count_reg, m_cell_count_next;
    logic [ashc_pkg::WORD_W-1:0]       m_word_count_reg, m_word_count_next;

    logic                              ram_we;
    logic [SLOT_W-1:0]                 ram_waddr, ram_raddr;
    logic [ROW_W-1:0]                  ram_wdata, ram_rdata;
    ashc_pkg::slot_row_t               rd_row, wr_row;

    logic                              hash_start, hash_done;
    logic [SLOT_W-1:0]                 hash_slot;

    logic                              accept, key_mode, drain_ok;
    logic [SLOT_W-1:0]                 drain_addr, probe_inc;
    logic [CNT_W-1:0]                  entries_inc;
    logic [ashc_pkg::CELL_W-1:0]       cells_sat;
    logic [WSUM_W-1:0]                 wsum;
    logic [ashc_pkg::WORD_W-1:0]       words_sat;

    logic                              sweep_start, result_move, inserting;

    ashc_slot_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_key),
        .done    (hash_done),
        .slot    (hash_slot)
    );

    ashc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_row    = ashc_pkg::slot_row_t'(ram_rdata);
    assign ram_wdata = ROW_W'(wr_row);

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign key_mode   = (s_mode == ashc_pkg::MODE_REGISTER) || (s_mode == ashc_pkg::MODE_COUNT);
    assign hash_start = accept && key_mode && (s_key != '0);
    assign drain_ok   = (32'(s_slot_index) < 32'(TABLE_SLOTS));
    assign drain_addr = SLOT_W'(s_slot_index);
    assign probe_inc  = (probe_idx_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0
                                                                     : probe_idx_reg + 1'b1;
    assign entries_inc = entries_reg + 1'b1;

    // Saturating counter updates for a count item, taken from the captured row.
    assign cells_sat = (row_reg.cells == '1) ? row_reg.cells : row_reg.cells + 1'b1;
    assign wsum      = {1'b0, row_reg.words} + WSUM_W'(obj_reg);
    assign words_sat = wsum[WSUM_W-1] ? '1 : wsum[ashc_pkg::WORD_W-1:0];

    always_comb begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        key_next          = key_reg;
        obj_next          = obj_reg;
        probe_idx_next    = probe_idx_reg;
        probe_cnt_next    = probe_cnt_reg;
        clr_idx_next      = clr_idx_reg;
        entries_next      = entries_reg;
        hit_next          = hit_reg;
        row_next          = row_reg;
        res_status_next   = res_status_reg;
        res_id_next       = res_id_reg;
        res_cells_next    = res_cells_reg;
        res_words_next    = res_words_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_site_id_next    = m_site_id_reg;
        m_cell_count_next = m_cell_count_reg;
        m_word_count_next = m_word_count_reg;
        ram_we            = 1'b0;
        ram_waddr         = probe_idx_reg;
        ram_raddr         = probe_idx_reg;
        wr_row            = '0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ram_raddr = drain_addr;
                if (accept) begin
                    mode_next       = s_mode;
                    key_next        = s_key;
                    obj_next        = s_object_words;
                    res_status_next = ashc_pkg::STATUS_NOT_FOUND;
                    res_id_next     = '0;
                    res_cells_next  = '0;
                    res_words_next  = '0;
                    if (hash_start) begin
                        state_next = ST_HASH;
                    end else if (s_mode == ashc_pkg::MODE_DRAIN && drain_ok) begin
                        probe_idx_next = drain_addr;
                        state_next     = ST_DRAIN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HASH: begin
                ram_raddr = hash_slot;
                if (hash_done) begin
                    probe_idx_next = hash_slot;
                    probe_cnt_next = '0;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // Read data belongs to probe_idx_reg; the next slot is fetched meanwhile.
                ram_raddr = probe_inc;
                if (rd_row.key == key_reg) begin
                    hit_next   = 1'b1;
                    row_next   = rd_row;
                    state_next = ST_UPDATE;
                end else if (rd_row.key == '0) begin
                    hit_next   = 1'b0;
                    state_next = ST_UPDATE;
                end else if (probe_cnt_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    res_status_next = (mode_reg == ashc_pkg::MODE_REGISTER)
                                    ? ashc_pkg::STATUS_FULL : ashc_pkg::STATUS_NOT_FOUND;
                    state_next      = ST_DONE;
                end else begin
                    probe_idx_next = probe_inc;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                state_next = ST_DONE;
                if (mode_reg == ashc_pkg::MODE_REGISTER) begin
                    res_status_next = ashc_pkg::STATUS_OK;
                    if (hit_reg) begin
                        res_id_next    = row_reg.id;
                        res_cells_next = row_reg.cells;
                        res_words_next = row_reg.words;
                    end else begin
                        entries_next = entries_inc;
                        wr_row.key   = key_reg;
                        wr_row.id    = ashc_pkg::ID_W'(entries_inc);
                        ram_we       = 1'b1;
                        res_id_next  = ashc_pkg::ID_W'(entries_inc);
                    end
                end else if (hit_reg) begin
                    wr_row.key      = key_reg;
                    wr_row.id       = row_reg.id;
                    wr_row.cells    = cells_sat;
                    wr_row.words    = words_sat;
                    ram_we          = 1'b1;
                    res_status_next = ashc_pkg::STATUS_OK;
                    res_id_next     = row_reg.id;
                    res_cells_next  = cells_sat;
                    res_words_next  = words_sat;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
                if (rd_row.key != '0) begin
                    res_id_next = rd_row.id;
                    if (rd_row.cells != '0) begin
                        res_status_next = ashc_pkg::STATUS_OK;
                        res_cells_next  = rd_row.cells;
                        res_words_next  = rd_row.words;
                        wr_row.key      = rd_row.key;
                        wr_row.id       = rd_row.id;
                        ram_we          = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_site_id_next    = res_id_reg;
                    m_cell_count_next = res_cells_reg;
                    m_word_count_next = res_words_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            entries_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            entries_reg <= entries_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg         <= mode_next;
        key_reg          <= key_next;
        obj_reg          <= obj_next;
        probe_idx_reg    <= probe_idx_next;
        probe_cnt_reg    <= probe_cnt_next;
        hit_reg          <= hit_next;
        row_reg          <= row_next;
        res_status_reg   <= res_status_next;
        res_id_reg       <= res_id_next;
        res_cells_reg    <= res_cells_next;
        res_words_reg    <= res_words_next;
        m_status_reg     <= m_status_next;
        m_site_id_reg    <= m_site_id_next;
        m_cell_count_reg <= m_cell_count_next;
        m_word_count_reg <= m_word_count_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_site_id    = m_site_id_reg;
    assign m_cell_count = m_cell_count_reg;
    assign m_word_count = m_word_count_reg;

    assign sweep_start = (state_reg == ST_CLEAR) && !m_valid_reg;
    assign result_move = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign inserting   = (state_reg == ST_UPDATE) && (mode_reg == ashc_pkg::MODE_REGISTER)
                         && !hit_reg;

    `ASHC_ASSERT_RST(a_reset_clears, !aresetn |=> sweep_start, "no clearing sweep after reset")
    `ASHC_ASSERT(a_hash_done_in_hash, hash_done |-> state_reg == ST_HASH, "stray hash result")
    `ASHC_ASSERT(a_done_delivers, result_move |=> (m_valid_reg && s_ready), "result not moved out")
    `ASHC_ASSERT(a_entries_insert_only, !inserting |=> $stable(entries_reg), "stray entry count")

endmodule

// ===== rtl/ashc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ashc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ashc_slot_hash.sv =====
// Iterative key hash: six shared mix steps, then a reciprocal reduction to a slot (low bits for a power of two).
`timescale 1ns / 1ps
`include "alloc_site_hash_counter_unit_macros.svh"

module ashc_slot_hash #(
    parameter int TABLE_SLOTS = ashc_pkg::TABLE_SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ashc_pkg::KEY_W-1:0]     key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

    localparam int   SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int   REM_W   = SLOT_W + 1;
    localparam int   HW      = ashc_pkg::HASH_W;
    localparam logic IS_POW2 = ((1 << SLOT_W) == TABLE_SLOTS);
    // Reciprocal of the table size scaled by 2^32; the quotient estimate is low by at most one.
    localparam logic [HW-1:0] RECIP = HW'((64'd1 << HW) / 64'(TABLE_SLOTS));

    typedef enum logic [1:0] {H_IDLE, H_MIX, H_MOD} phase_t;

    phase_t                       phase_reg, phase_next;
    logic [2:0]                   step_reg, step_next;
    logic [ashc_pkg::KEY_W-1:0]   k_reg, k_next;
    logic [1:0]                   mod_step_reg, mod_step_next;
    logic [HW-1:0]                h_reg, h_next;
    logic [HW-1:0]                q_reg, q_next;
    logic [REM_W-1:0]             rest_reg, rest_next;
    logic                         done_reg, done_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;

    ashc_pkg::mix_op_t            op;
    logic [ashc_pkg::KEY_W-1:0]   mix_a, mix_shift, mix_c, mix_out;
    logic [2*HW-1:0]              q_prod;
    logic [HW-1:0]                rest_full;
    logic [REM_W-1:0]             rest_sub;
    logic [SLOT_W-1:0]            rem_final;

    always_comb begin
        op        = ashc_pkg::mix_op(step_reg);
        mix_a     = op.inv_a ? ~k_reg : k_reg;
        mix_shift = op.shl ? (k_reg << op.shamt) : (k_reg >> op.shamt);
        mix_c     = op.mul21 ? (k_reg << ashc_pkg::MIX_MUL_SHL_HI) : '0;
        mix_out   = op.add ? (mix_a + mix_shift + mix_c) : (mix_a ^ mix_shift);

        // Remainder by the table size: estimate the quotient, subtract, then correct once.
        q_prod    = (2*HW)'(h_reg) * (2*HW)'(RECIP);
        rest_full = h_reg - q_reg * HW'(TABLE_SLOTS);
        rest_sub  = rest_reg - REM_W'(TABLE_SLOTS);
        rem_final = (rest_reg >= REM_W'(TABLE_SLOTS)) ? rest_sub[SLOT_W-1:0]
                                                       : rest_reg[SLOT_W-1:0];
    end

    always_comb begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        k_next        = k_reg;
        mod_step_next = mod_step_reg;
        h_next        = h_reg;
        q_next        = q_reg;
        rest_next     = rest_reg;
        done_next     = 1'b0;
        slot_next     = slot_reg;
        case (phase_reg)
            H_IDLE: begin
                if (start) begin
                    k_next     = key;
                    step_next  = '0;
                    phase_next = H_MIX;
                end
            end
            H_MIX: begin
                k_next    = mix_out;
                step_next = step_reg + 3'd1;
                if (step_reg == ashc_pkg::MIX_LAST) begin
                    if (IS_POW2) begin
                        slot_next  = mix_out[SLOT_W-1:0];
                        done_next  = 1'b1;
                        phase_next = H_IDLE;
                    end else begin
                        h_next        = mix_out[HW-1:0];
                        mod_step_next = '0;
                        phase_next    = H_MOD;
                    end
                end
            end
            H_MOD: begin
                mod_step_next = mod_step_reg + 2'd1;
                case (mod_step_reg)
                    2'd0: begin
                        q_next = q_prod[2*HW-1:HW];
                    end
                    2'd1: begin
                        rest_next = rest_full[REM_W-1:0];
                    end
                    default: begin
                        slot_next  = rem_final;
                        done_next  = 1'b1;
                        phase_next = H_IDLE;
                    end
                endcase
            end
            default: begin
                phase_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        step_reg     <= step_next;
        k_reg        <= k_next;
        mod_step_reg <= mod_step_next;
        h_reg        <= h_next;
        q_reg        <= q_next;
        rest_reg     <= rest_next;
        slot_reg     <= slot_next;
    end

    assign done = done_reg;
    assign slot = slot_reg;

    `ASHC_ASSERT(a_start_when_idle, start |-> phase_reg == H_IDLE, "hash started while busy")
    `ASHC_ASSERT(a_done_single, done_reg |=> !done_reg, "hash done held longer than one cycle")
    `ASHC_ASSERT(a_step_range, phase_reg == H_MIX |-> step_reg <= ashc_pkg::MIX_LAST, "bad mix step")

endmodule

// ===== tb/ashc_checker.sv =====
// Checker for the allocation-site hash counter: predicts each result and compares it.
`timescale 1ns / 1ps

module ashc_checker
    import ashc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [KEY_W-1:0]      s_key,
    input  logic [OBJ_W-1:0]      s_object_words,
    input  logic [SLOT_IDX_W-1:0] s_slot_index,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [STATUS_W-1:0]   m_status,
    input  logic [ID_W-1:0]       m_site_id,
    input  logic [CELL_W-1:0]     m_cell_count,
    input  logic [WORD_W-1:0]     m_word_count,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int SLOTS = TABLE_SLOTS_DEFAULT;

    typedef enum logic [1:0] {PROBE_HIT, PROBE_EMPTY, PROBE_WRAP} probe_e;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [CELL_W-1:0]   cells;
        logic [WORD_W-1:0]   words;
    } site_result_t;

    logic [KEY_W-1:0]  site_key   [SLOTS];
    logic [ID_W-1:0]   site_id    [SLOTS];
    logic [CELL_W-1:0] site_cells [SLOTS];
    logic [WORD_W-1:0] site_words [SLOTS];
    logic [ID_W-1:0]   sites_used;

    site_result_t expected_q [$];
    int           fail_tally = 0;

    assign mismatches = fail_tally;

    function automatic logic [HASH_W-1:0] site_hash(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = ~k + (k << MIX_SHL_A);
        h = h ^ (h >> MIX_SHR_A);
        h = h * 64'd21;
        h = h ^ (h >> MIX_SHR_B);
        h = h + (h << MIX_SHL_B);
        h = h ^ (h >> MIX_SHR_C);
        return h[HASH_W-1:0];
    endfunction

    // Linear probe from the hashed slot; stops at the key, at an empty slot or after a full lap.
    function automatic probe_e find_slot(input logic [KEY_W-1:0] k, output int at);
        int i;
        i = int'(site_hash(k) % 32'(SLOTS));
        for (int n = 0; n < SLOTS; n++) begin
            if (site_key[i] == k) begin
                at = i;
                return PROBE_HIT;
            end
            if (site_key[i] == '0) begin
                at = i;
                return PROBE_EMPTY;
            end
            i = (i + 1) % SLOTS;
        end
        at = 0;
        return PROBE_WRAP;
    endfunction

    function automatic site_result_t apply_item(input logic [MODE_W-1:0] mode,
                                                input logic [KEY_W-1:0] key,
                                                input logic [OBJ_W-1:0] words,
                                                input logic [SLOT_IDX_W-1:0] sidx);
        site_result_t r;
        probe_e       hit;
        int           at;
        logic [WORD_W:0] sum;
        r = '0;
        r.status = STATUS_NOT_FOUND;
        case (mode)
            MODE_REGISTER: if (key != '0) begin
                hit = find_slot(key, at);
                if (hit == PROBE_HIT) begin
                    r.status = STATUS_OK;
                    r.id     = site_id[at];
                    r.cells  = site_cells[at];
                    r.words  = site_words[at];
                end else if (hit == PROBE_EMPTY) begin
                    sites_used     = sites_used + 1'b1;
                    site_key[at]   = key;
                    site_id[at]    = sites_used;
                    site_cells[at] = '0;
                    site_words[at] = '0;
                    r.status       = STATUS_OK;
                    r.id           = sites_used;
                end else begin
                    r.status = STATUS_FULL;
                end
            end
            MODE_COUNT: if (key != '0) begin
                hit = find_slot(key, at);
                if (hit == PROBE_HIT) begin
                    if (site_cells[at] != '1) begin
                        site_cells[at] = site_cells[at] + 1'b1;
                    end
                    sum = {1'b0, site_words[at]} + words;
                    site_words[at] = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
                    r.status = STATUS_OK;
                    r.id     = site_id[at];
                    r.cells  = site_cells[at];
                    r.words  = site_words[at];
                end
            end
            MODE_DRAIN: if (site_key[sidx] != '0) begin
                r.id = site_id[sidx];
                // A slot that counted nothing since its last drain reports idle but keeps its id.
                if (site_cells[sidx] != '0) begin
                    r.status         = STATUS_OK;
                    r.cells          = site_cells[sidx];
                    r.words          = site_words[sidx];
                    site_cells[sidx] = '0;
                    site_words[sidx] = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_tally++;
    endtask

    always @(posedge aclk) begin
        site_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                site_key[i]   = '0;
                site_id[i]    = '0;
                site_cells[i] = '0;
                site_words[i] = '0;
            end
            sites_used = '0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no item pending", m_status, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_site_id !== want.id)
                        report_mismatch("site_id", m_site_id, want.id);
                    if (m_cell_count !== want.cells)
                        report_mismatch("cell_count", m_cell_count, want.cells);
                    if (m_word_count !== want.words)
                        report_mismatch("word_count", m_word_count, want.words);
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(apply_item(s_mode, s_key, s_object_words, s_slot_index));
            end
        end
        outstanding <= expected_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the allocation-site hash counter: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ashc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 400;
    localparam int POOL_SIZE     = 320;
    localparam int HOT_COUNTS    = 260;
    localparam int RANDOM_ITEMS  = 350;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode = '0;
    logic [KEY_W-1:0]      s_key = '0;
    logic [OBJ_W-1:0]      s_object_words = '0;
    logic [SLOT_IDX_W-1:0] s_slot_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [ID_W-1:0]       m_site_id;
    logic [CELL_W-1:0]     m_cell_count;
    logic [WORD_W-1:0]     m_word_count;

    int mismatches;
    int outstanding;
    int send_idle = 20;
    int recv_idle = 53;
    int quiet_cycles = 0;

    logic [KEY_W-1:0] site_pool [POOL_SIZE];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    alloc_site_hash_counter_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_key          (s_key),
        .s_object_words (s_object_words),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_site_id      (m_site_id),
        .m_cell_count   (m_cell_count),
        .m_word_count   (m_word_count)
    );

    ashc_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_key          (s_key),
        .s_object_words (s_object_words),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_site_id      (m_site_id),
        .m_cell_count   (m_cell_count),
        .m_word_count   (m_word_count),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called right after a rising edge; returns right after the edge that accepts the item.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [OBJ_W-1:0] words,
                             input logic [SLOT_IDX_W-1:0] sidx);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_key          <= key;
        s_object_words <= words;
        s_slot_index   <= sidx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [OBJ_W-1:0] pick_words();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item(input int pool_top);
        int               pick;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(99);
        key  = site_pool[$urandom_range(pool_top)];
        if (pick < 30) begin
            send_item(MODE_REGISTER, key, $urandom, $urandom_range(255));
        end else if (pick < 75) begin
            // Now and then a key that was never registered.
            if ($urandom_range(9) == 0) key = {$urandom, $urandom};
            send_item(MODE_COUNT, key, pick_words(), $urandom_range(255));
        end else if (pick < 90) begin
            send_item(MODE_DRAIN, {$urandom, $urandom}, $urandom, $urandom_range(255));
        end else if (pick < 95) begin
            send_item(MODE_UNUSED, {$urandom, $urandom}, $urandom, $urandom_range(255));
        end else begin
            send_item(pick[0] ? MODE_COUNT : MODE_REGISTER, '0, $urandom, $urandom_range(255));
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            site_pool[i] = {$urandom, $urandom};
            if (site_pool[i] == '0) site_pool[i] = 64'd1;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table, unused mode, key zero and edge keys first.
        send_item(MODE_DRAIN, '0, '0, 8'd0);
        send_item(MODE_DRAIN, '1, '1, 8'd255);
        send_item(MODE_UNUSED, '1, '1, 8'd255);
        send_item(MODE_REGISTER, '0, '1, 8'd0);
        send_item(MODE_COUNT, '0, '1, 8'd0);
        send_item(MODE_COUNT, site_pool[0], 32'd5, 8'd0);
        send_item(MODE_REGISTER, '1, '0, 8'd0);
        send_item(MODE_REGISTER, 64'd1, '0, 8'd0);
        send_item(MODE_REGISTER, '1, '0, 8'd0);
        send_item(MODE_COUNT, '1, '1, 8'd0);
        send_item(MODE_COUNT, '1, '0, 8'd0);
        send_item(MODE_COUNT, 64'd1, 32'd1, 8'd0);
        send_item(MODE_REGISTER, site_pool[0], '0, 8'd0);
        send_item(MODE_COUNT, site_pool[0], 32'h8000_0000, 8'd0);
        send_item(MODE_REGISTER, 64'h8000_0000_0000_0000, '0, 8'd0);
        send_item(MODE_DRAIN, '0, '0, 8'd64);
        send_item(MODE_DRAIN, '0, '0, 8'd128);
        send_item(MODE_DRAIN, '0, '0, 8'd192);

        for (int i = 0; i < RANDOM_ITEMS; i++) random_item(63);

        send_idle = 53;
        recv_idle = 20;
        for (int i = 0; i < RANDOM_ITEMS; i++) random_item(159);

        send_idle = 0;
        recv_idle = 0;
        // Enough maximum-size objects on one site to saturate its word count.
        send_item(MODE_REGISTER, site_pool[0], '0, 8'd0);
        for (int i = 0; i < HOT_COUNTS; i++) begin
            send_item(MODE_COUNT, site_pool[0], '1, $urandom_range(255));
        end
        // Registering the whole pool fills the table and runs into refusals.
        for (int i = 0; i < POOL_SIZE; i++) begin
            send_item(MODE_REGISTER, site_pool[i], $urandom, $urandom_range(255));
        end
        for (int i = 0; i < 100; i++) random_item(POOL_SIZE - 1);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ashc_pkg.sv
rtl/ashc_ram.sv
rtl/ashc_slot_hash.sv
rtl/alloc_site_hash_counter_unit.sv
tb/ashc_checker.sv
tb/tb_top.sv
